[rtl/core/tsc_pkg.sv]
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types, codes and constants of the two-register stack processor core.
// ----------------------------------------------------------------------------
package tsc_pkg;

   localparam int unsigned MEM_DEPTH_DEF  = 4096;
   localparam logic [12:0] PROG_LEN_RESET = 13'd4096;
   localparam logic [30:0] STEP_LIM_RESET = 31'd100000;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_EXEC  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [2:0] ST_RUN   = 3'd0;
   localparam logic [2:0] ST_HALT  = 3'd1;
   localparam logic [2:0] ST_PC    = 3'd2;
   localparam logic [2:0] ST_OPC   = 3'd3;
   localparam logic [2:0] ST_MEM   = 3'd4;
   localparam logic [2:0] ST_LIMIT = 3'd5;

   localparam logic [7:0] OP_LDC  = 8'd0;
   localparam logic [7:0] OP_ADC  = 8'd1;
   localparam logic [7:0] OP_LDL  = 8'd2;
   localparam logic [7:0] OP_STL  = 8'd3;
   localparam logic [7:0] OP_LDNL = 8'd4;
   localparam logic [7:0] OP_STNL = 8'd5;
   localparam logic [7:0] OP_ADD  = 8'd6;
   localparam logic [7:0] OP_SUB  = 8'd7;
   localparam logic [7:0] OP_SHL  = 8'd8;
   localparam logic [7:0] OP_SHR  = 8'd9;
   localparam logic [7:0] OP_ADJ  = 8'd10;
   localparam logic [7:0] OP_A2SP = 8'd11;
   localparam logic [7:0] OP_SP2A = 8'd12;
   localparam logic [7:0] OP_CALL = 8'd13;
   localparam logic [7:0] OP_RET  = 8'd14;
   localparam logic [7:0] OP_BRZ  = 8'd15;
   localparam logic [7:0] OP_BRLZ = 8'd16;
   localparam logic [7:0] OP_BR   = 8'd17;
   localparam logic [7:0] OP_HALT = 8'd18;

   localparam logic csr_IDX_PLEN = 1'b0;

   typedef struct packed {
      logic [1:0]  command;
      logic [11:0] address;
      logic [31:0] data;
   } tsc_req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] reg_a;
      logic signed [31:0] reg_b;
      logic signed [31:0] prog_counter;
      logic signed [31:0] stack_pointer;
      logic [31:0]        read_data;
      logic [30:0]        executed_count;
   } tsc_rsp_type;

   typedef enum logic [1:0] {
      J_WRITE,
      J_EXEC,
      J_READ,
      J_NOP
   } tsc_kind_type;

   typedef struct packed {
      tsc_kind_type kind;
      logic         host_ok;
      logic [11:0]  address;
      logic [31:0]  data;
   } tsc_job_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } tsc_ctl_type;

   function automatic logic [31:0] operand_of(input logic [31:0] w);
      return {{8{w[31]}}, w[31:8]};
   endfunction

endpackage

[rtl/core/tsc_ram.sv]
// ----------------------------------------------------------------------------
// tsc_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tsc_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/tsc_front.sv]
// ----------------------------------------------------------------------------
// tsc_front
// Accepts requests, classifies the command and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tsc_front #(
   parameter int unsigned MEM_DEPTH = tsc_pkg::MEM_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tsc_pkg::tsc_req_type req_item,
   input  tsc_pkg::tsc_ctl_type ctl,
   output logic                 head_valid,
   output tsc_pkg::tsc_job_type head
);
   import tsc_pkg::*;

   tsc_job_type q_ff [2];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   tsc_job_type job;
   logic        push;

   always_comb begin
      job.address = req_item.address;
      job.data    = req_item.data;
      job.host_ok = 32'(req_item.address) < 32'(MEM_DEPTH);
      case (req_item.command)
         CMD_WRITE: job.kind = J_WRITE;
         CMD_EXEC:  job.kind = J_EXEC;
         CMD_READ:  job.kind = J_READ;
         default:   job.kind = J_NOP;
      endcase
   end

   assign req_ready  = (cnt_ff != 2'd2) && !ctl.clearing;
   assign push       = req_valid && req_ready;
   assign head_valid = cnt_ff != 2'd0;
   assign head       = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = ctl.pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(ctl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff] <= job;
      end
   end

endmodule

[rtl/core/tsc_back.sv]
// ----------------------------------------------------------------------------
// tsc_back
// Carries out queued commands against the registers and the word memory.
// ----------------------------------------------------------------------------
module tsc_back #(
   parameter int unsigned MEM_DEPTH = tsc_pkg::MEM_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  tsc_pkg::tsc_job_type head,
   output tsc_pkg::tsc_ctl_type ctl,
   input  logic [12:0]          prog_len,
   input  logic [30:0]          step_lim,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tsc_pkg::tsc_rsp_type rsp_item
);
   import tsc_pkg::*;

   localparam int unsigned AW   = $clog2(MEM_DEPTH);
   localparam logic [AW-1:0]   LAST = AW'(MEM_DEPTH - 1);
   localparam logic [31:0]     DEPTH32 = 32'(MEM_DEPTH);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_DECODE,
      S_LOAD,
      S_RESP
   } state_type;

   state_type   state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [31:0] a_ff, a_in, b_ff, b_in, pc_ff, pc_in, sp_ff, sp_in, rd_ff, rd_in;
   logic [30:0] cnt_ff, cnt_in;
   logic [2:0]  stop_ff, stop_in;
   logic        rsp_valid_ff, rsp_valid_in;
   tsc_rsp_type rsp_item_ff, rsp_item_in;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [31:0]   ram_wdata, ram_rdata;

   logic [31:0] w, opd, ea, target;
   logic [7:0]  opc;
   logic        ea_ok;

   tsc_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      w      = ram_rdata;
      opc    = w[7:0];
      opd    = operand_of(w);
      ea     = ((opc == OP_LDL || opc == OP_STL) ? sp_ff : a_ff) + opd;
      ea_ok  = !ea[31] && (ea < DEPTH32);
      target = pc_ff + opd;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      pc_in        = pc_ff;
      sp_in        = sp_ff;
      rd_in        = rd_ff;
      cnt_in       = cnt_ff;
      stop_in      = stop_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      ram_we       = 1'b0;
      ram_addr     = '0;
      ram_wdata    = '0;
      ctl.pop      = 1'b0;
      ctl.clearing = state_ff == S_CLEAR;
      case (state_ff)
         S_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = clr_ff;
            clr_in   = clr_ff + AW'(1);
            if (clr_ff == LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (head_valid) begin
               ctl.pop  = 1'b1;
               rd_in    = '0;
               state_in = S_RESP;
               case (head.kind)
                  J_WRITE: begin
                     ram_we    = head.host_ok;
                     ram_addr  = AW'(head.address);
                     ram_wdata = head.data;
                  end
                  J_READ: begin
                     ram_addr = AW'(head.address);
                     if (head.host_ok) begin
                        state_in = S_READ;
                     end
                  end
                  J_EXEC: begin
                     ram_addr = pc_ff[AW-1:0];
                     if (stop_ff != ST_RUN) begin
                        stop_in = stop_ff;
                     end else if (cnt_ff >= step_lim) begin
                        stop_in = ST_LIMIT;
                     end else if (pc_ff[31] || pc_ff >= {19'd0, prog_len} ||
                                  pc_ff >= DEPTH32) begin
                        stop_in = ST_PC;
                     end else begin
                        pc_in    = pc_ff + 32'd1;
                        state_in = S_DECODE;
                     end
                  end
                  default: begin
                     rd_in = '0;
                  end
               endcase
            end
         end
         S_READ: begin
            rd_in    = ram_rdata;
            state_in = S_RESP;
         end
         S_DECODE: begin
            state_in = S_RESP;
            cnt_in   = cnt_ff + 31'd1;
            case (opc)
               OP_LDC: begin
                  b_in = a_ff;
                  a_in = opd;
               end
               OP_ADC:  a_in = a_ff + opd;
               OP_LDL, OP_LDNL: begin
                  if (opc == OP_LDL) begin
                     b_in = a_ff;
                  end
                  ram_addr = ea[AW-1:0];
                  cnt_in   = cnt_ff;
                  if (ea_ok) begin
                     state_in = S_LOAD;
                  end else begin
                     stop_in = ST_MEM;
                  end
               end
               OP_STL, OP_STNL: begin
                  ram_addr  = ea[AW-1:0];
                  ram_wdata = (opc == OP_STL) ? a_ff : b_ff;
                  ram_we    = ea_ok;
                  if (opc == OP_STL) begin
                     a_in = b_ff;
                  end
                  if (!ea_ok) begin
                     stop_in = ST_MEM;
                     cnt_in  = cnt_ff;
                  end
               end
               OP_ADD:  a_in = b_ff + a_ff;
               OP_SUB:  a_in = b_ff - a_ff;
               OP_SHL:  a_in = b_ff << a_ff[4:0];
               OP_SHR:  a_in = b_ff >> a_ff[4:0];
               OP_ADJ:  sp_in = sp_ff + opd;
               OP_A2SP: begin
                  sp_in = a_ff;
                  a_in  = b_ff;
               end
               OP_SP2A: begin
                  b_in = a_ff;
                  a_in = sp_ff;
               end
               OP_CALL: begin
                  b_in  = a_ff;
                  a_in  = pc_ff;
                  pc_in = target;
               end
               OP_RET: begin
                  pc_in = a_ff;
                  a_in  = b_ff;
               end
               OP_BRZ: begin
                  if (a_ff == 32'd0) begin
                     pc_in = target;
                  end
               end
               OP_BRLZ: begin
                  if (a_ff[31]) begin
                     pc_in = target;
                  end
               end
               OP_BR:   pc_in = target;
               OP_HALT: stop_in = ST_HALT;
               default: begin
                  stop_in = ST_OPC;
                  cnt_in  = cnt_ff;
               end
            endcase
         end
         S_LOAD: begin
            a_in     = ram_rdata;
            cnt_in   = cnt_ff + 31'd1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_item_in.status         = stop_ff;
               rsp_item_in.reg_a          = $signed(a_ff);
               rsp_item_in.reg_b          = $signed(b_ff);
               rsp_item_in.prog_counter   = $signed(pc_ff);
               rsp_item_in.stack_pointer  = $signed(sp_ff);
               rsp_item_in.read_data      = rd_ff;
               rsp_item_in.executed_count = cnt_ff;
               state_in                   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         a_ff         <= '0;
         b_ff         <= '0;
         pc_ff        <= '0;
         sp_ff        <= '0;
         cnt_ff       <= '0;
         stop_ff      <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         pc_ff        <= pc_in;
         sp_ff        <= sp_in;
         cnt_ff       <= cnt_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_ff       <= rd_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

[rtl/core/two_register_stack_cpu_core.sv]
// ----------------------------------------------------------------------------
// two_register_stack_cpu_core
// Two-register processor with host access to its word memory.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Moves
// req       in         req_valid/req_ready   one request (command, address, data)
// rsp       out        rsp_valid/rsp_ready   one result per request
// csr       in         psel/penable/pwrite   program_length, step_limit
//
// A write, an unknown command, a read outside the memory and an execute that
// stops before its fetch go straight to the result; a read passes S_READ and an
// instruction S_DECODE first, a load S_DECODE and S_LOAD, as the single memory
// port serves fetch, operand access and host access. After reset the memory
// is cleared word by word with req_ready low. A two-entry queue and the result
// register buffer requests while rsp_ready is low, until the queue is full.
// ----------------------------------------------------------------------------
module two_register_stack_cpu_core #(
   parameter int unsigned MEM_DEPTH = tsc_pkg::MEM_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tsc_pkg::tsc_req_type req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tsc_pkg::tsc_rsp_type rsp_item,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import tsc_pkg::*;

   logic [12:0] plen_ff;
   logic [30:0] slim_ff;
   tsc_ctl_type ctl;
   tsc_job_type head;
   logic        head_valid;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == csr_IDX_PLEN) ? {19'd0, plen_ff} : {1'b0, slim_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= PROG_LEN_RESET;
         slim_ff <= STEP_LIM_RESET;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == csr_IDX_PLEN) begin
            plen_ff <= pwdata[12:0];
         end else begin
            slim_ff <= pwdata[30:0];
         end
      end
   end

   tsc_front #(.MEM_DEPTH(MEM_DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .ctl        (ctl),
      .head_valid (head_valid),
      .head       (head)
   );

   tsc_back #(.MEM_DEPTH(MEM_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .ctl        (ctl),
      .prog_len   (plen_ff),
      .step_lim   (slim_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

endmodule

[rtl/core/tsc_checker.sv]
// ----------------------------------------------------------------------------
// tsc_checker
// Port-level checks of the processor core, bound to its top level.
// ----------------------------------------------------------------------------
module tsc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input tsc_pkg::tsc_rsp_type rsp_item,
   input logic                 pready
);
   import tsc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("Stalled result changed.");

   a_reset_quiet: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready && !rsp_valid)
      else $error("Core active right after reset.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.status <= ST_LIMIT)
      else $error("Result status out of range.");

   a_pready: assert property (@(posedge clock) pready)
      else $error("pready dropped.");

endmodule

bind two_register_stack_cpu_core tsc_checker u_tsc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item),
   .pready    (pready)
);

[bench/tsc_checker.sv]
// ----------------------------------------------------------------------------
// tsc_scoreboard
// Watches the request, result and register ports of the two-register stack
// processor core, keeps its own copy of the core state and memory, predicts
// the result of every accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module tsc_scoreboard (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  tsc_pkg::tsc_req_type req_item,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tsc_pkg::tsc_rsp_type rsp_item,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic                 pready,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output int                   mismatch_count
);
   import tsc_pkg::*;

   localparam logic [2:0] ADDR_PROG_LEN  = 3'd0;
   localparam logic [2:0] ADDR_STEP_LIM  = 3'd4;
   localparam int         WORDS          = 4096;

   logic [31:0] shadow_mem [WORDS];
   logic [31:0] acc_a, acc_b, pc_val, sp_val;
   logic [30:0] steps_done;
   logic [2:0]  stop_state;
   logic [12:0] prog_len;
   logic [30:0] step_lim;
   tsc_rsp_type expected_results[$];

   function automatic void execute_instruction();
      logic [31:0] w, opd, ea;
      logic [7:0]  opc;
      logic        ok;
      if (stop_state != ST_RUN) return;
      if (steps_done >= step_lim) begin
         stop_state = ST_LIMIT;
         return;
      end
      if (pc_val[31] || pc_val >= {19'd0, prog_len} || pc_val >= WORDS) begin
         stop_state = ST_PC;
         return;
      end
      w = shadow_mem[pc_val[11:0]];
      opc = w[7:0];
      opd = {{8{w[31]}}, w[31:8]};
      pc_val = pc_val + 32'd1;
      ok = 1'b1;
      case (opc)
         OP_LDC: begin
            acc_b = acc_a;
            acc_a = opd;
         end
         OP_ADC: acc_a = acc_a + opd;
         OP_LDL: begin
            acc_b = acc_a;
            ea = sp_val + opd;
            if (ea < WORDS) acc_a = shadow_mem[ea[11:0]];
            else ok = 1'b0;
         end
         OP_STL: begin
            ea = sp_val + opd;
            if (ea < WORDS) shadow_mem[ea[11:0]] = acc_a;
            else ok = 1'b0;
            acc_a = acc_b;
         end
         OP_LDNL: begin
            ea = acc_a + opd;
            if (ea < WORDS) acc_a = shadow_mem[ea[11:0]];
            else ok = 1'b0;
         end
         OP_STNL: begin
            ea = acc_a + opd;
            if (ea < WORDS) shadow_mem[ea[11:0]] = acc_b;
            else ok = 1'b0;
         end
         OP_ADD: acc_a = acc_b + acc_a;
         OP_SUB: acc_a = acc_b - acc_a;
         OP_SHL: acc_a = acc_b << acc_a[4:0];
         OP_SHR: acc_a = acc_b >> acc_a[4:0];
         OP_ADJ: sp_val = sp_val + opd;
         OP_A2SP: begin
            sp_val = acc_a;
            acc_a = acc_b;
         end
         OP_SP2A: begin
            acc_b = acc_a;
            acc_a = sp_val;
         end
         OP_CALL: begin
            acc_b = acc_a;
            acc_a = pc_val;
            pc_val = pc_val + opd;
         end
         OP_RET: begin
            pc_val = acc_a;
            acc_a = acc_b;
         end
         OP_BRZ: if (acc_a == 0) pc_val = pc_val + opd;
         OP_BRLZ: if (acc_a[31]) pc_val = pc_val + opd;
         OP_BR: pc_val = pc_val + opd;
         OP_HALT: stop_state = ST_HALT;
         default: begin
            stop_state = ST_OPC;
            return;
         end
      endcase
      if (!ok) begin
         stop_state = ST_MEM;
         return;
      end
      steps_done = steps_done + 31'd1;
   endfunction

   function automatic tsc_rsp_type predict_result(input tsc_req_type r);
      tsc_rsp_type res;
      logic [31:0] rd;
      rd = '0;
      case (r.command)
         CMD_WRITE: shadow_mem[r.address] = r.data;
         CMD_EXEC: execute_instruction();
         CMD_READ: rd = shadow_mem[r.address];
         default: ;
      endcase
      res.status = stop_state;
      res.reg_a = acc_a;
      res.reg_b = acc_b;
      res.prog_counter = pc_val;
      res.stack_pointer = sp_val;
      res.read_data = rd;
      res.executed_count = steps_done;
      return res;
   endfunction

   always @(posedge clock) begin
      tsc_rsp_type want;
      if (reset) begin
         for (int i = 0; i < WORDS; i++) shadow_mem[i] = '0;
         acc_a = '0;
         acc_b = '0;
         pc_val = '0;
         sp_val = '0;
         steps_done = '0;
         stop_state = ST_RUN;
         prog_len = PROG_LEN_RESET;
         step_lim = STEP_LIM_RESET;
         expected_results.delete();
         mismatch_count <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == ADDR_PROG_LEN) prog_len = pwdata[12:0];
            else if (paddr == ADDR_STEP_LIM) step_lim = pwdata[30:0];
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               if (mismatch_count < 10) $display("Unexpected result: %p", rsp_item);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (rsp_item.status !== want.status || rsp_item.reg_a !== want.reg_a ||
                   rsp_item.reg_b !== want.reg_b ||
                   rsp_item.prog_counter !== want.prog_counter ||
                   rsp_item.stack_pointer !== want.stack_pointer ||
                   rsp_item.read_data !== want.read_data ||
                   rsp_item.executed_count !== want.executed_count) begin
                  if (mismatch_count < 10) begin
                     $display("Mismatch: expected %p", want);
                     $display("          actual   %p", rsp_item);
                  end
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_valid && req_ready) expected_results.push_back(predict_result(req_item));
      end
   end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the two-register stack processor core with host writes and reads
// and with instructions placed at the program counter just before they run,
// so that long programs execute without faulting. Register settings change
// between phases, and the run ends by stopping the core in one random way.
// ----------------------------------------------------------------------------
module testbench;
   import tsc_pkg::*;

   localparam logic [1:0] CMD_NONE      = 2'd3;
   localparam logic [2:0] ADDR_PROG_LEN = 3'd0;
   localparam logic [2:0] ADDR_STEP_LIM = 3'd4;
   localparam int         CYCLE_LIMIT   = 600000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   tsc_req_type req_item = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   tsc_rsp_type rsp_item;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   int          mismatch_count;
   int          sent = 0;
   int          received = 0;
   int          cycles = 0;
   int          plen_now = 4096;
   bit          quiet = 1'b0;
   tsc_rsp_type last_result = '0;

   two_register_stack_cpu_core uut (.*);

   tsc_scoreboard u_scoreboard (
      .clock, .reset, .req_valid, .req_ready, .req_item, .rsp_valid, .rsp_ready,
      .rsp_item, .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .mismatch_count
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= quiet || ($urandom_range(0, 99) >= 33);
      if (rsp_valid && rsp_ready) begin
         received <= received + 1;
         last_result <= rsp_item;
      end
   end

   task automatic send_request(input logic [1:0] cmd, input logic [11:0] addr,
                               input logic [31:0] data);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 99) < 33) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= '{command: cmd, address: addr, data: data};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (received != sent);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      drain();
      repeat (10) @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_PROG_LEN) plen_now = int'(value[12:0]);
   endtask

   task automatic exec_word(input logic [31:0] w);
      send_request(CMD_WRITE, last_result.prog_counter[11:0], w);
      send_request(CMD_EXEC, 12'($urandom), $urandom);
      drain();
   endtask

   // Builds an instruction whose memory access and next fetch stay in range.
   task automatic exec_safe(input bit forced, input logic [7:0] op_in);
      logic [7:0] op;
      longint     pcv, av, spv, d;
      int         tgt, mt;
      pcv = longint'(last_result.prog_counter);
      av = longint'(last_result.reg_a);
      spv = longint'(last_result.stack_pointer);
      op = forced ? op_in : 8'($urandom_range(0, 17));
      tgt = $urandom_range(0, plen_now - 1);
      mt = $urandom_range(0, 4095);
      d = longint'($urandom_range(0, 16777215)) - 8388608;
      case (op)
         OP_LDL, OP_STL: d = mt - spv;
         OP_LDNL, OP_STNL: d = mt - av;
         OP_CALL, OP_BR, OP_BRZ, OP_BRLZ: d = tgt - (pcv + 1);
         OP_RET: if (av < 0 || av >= plen_now) op = OP_ADC;
         default: ;
      endcase
      if (d < -8388608 || d > 8388607) begin
         op = OP_LDC;
         d = mt;
      end
      if (pcv + 1 >= plen_now && !(op == OP_BR || op == OP_CALL || op == OP_RET)) begin
         op = OP_BR;
         d = tgt - (pcv + 1);
      end
      exec_word({d[23:0], op});
   endtask

   task automatic random_round();
      int n;
      logic [1:0] cmd;
      if ($urandom_range(0, 99) < 60) begin
         exec_safe(1'b0, OP_LDC);
      end else begin
         n = $urandom_range(1, 4);
         repeat (n) begin
            cmd = ($urandom_range(0, 1) == 0) ? CMD_WRITE : CMD_READ;
            if ($urandom_range(0, 19) == 0) cmd = CMD_NONE;
            send_request(cmd, 12'($urandom), $urandom);
         end
      end
   endtask

   initial begin
      int stop_kind;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_request(CMD_WRITE, 12'd0, 32'h0000_0000);
      send_request(CMD_WRITE, 12'hFFF, 32'hFFFF_FFFF);
      send_request(CMD_READ, 12'hFFF, 32'h0);
      send_request(CMD_READ, 12'd0, 32'hFFFF_FFFF);
      send_request(CMD_NONE, 12'hFFF, 32'hFFFF_FFFF);
      drain();
      for (int op = 0; op <= 17; op++) exec_safe(1'b1, 8'(op));

      csr_write(ADDR_PROG_LEN, 32'd4096);
      csr_write(ADDR_STEP_LIM, 32'h7FFF_FFFF);
      while (sent < 500) begin
         quiet = (sent >= 250 && sent < 450);
         random_round();
      end
      quiet = 1'b0;

      exec_word({24'(-(longint'(last_result.prog_counter) + 1)), OP_BR});
      csr_write(ADDR_PROG_LEN, 32'd1);
      repeat (6) exec_safe(1'b0, OP_LDC);

      csr_write(ADDR_PROG_LEN, $urandom_range(2, 4096));
      csr_write(ADDR_STEP_LIM, $urandom_range(100000, 32'h7FFF_FFFF));
      while (sent < 1250) random_round();

      stop_kind = $urandom_range(0, 4);
      case (stop_kind)
         0: exec_word({24'd0, OP_HALT});
         1: exec_word({24'($urandom), 8'($urandom_range(19, 255))});
         2: begin
            exec_word({24'(plen_now - (longint'(last_result.prog_counter) + 1)), OP_BR});
            send_request(CMD_EXEC, 12'd0, 32'd0);
         end
         3: begin
            exec_safe(1'b1, OP_LDC);
            exec_word({24'h00_0000, OP_LDC});
            exec_word({24'hFF_FFFF, OP_LDNL});
         end
         default: begin
            csr_write(ADDR_STEP_LIM, 32'd1);
            send_request(CMD_EXEC, 12'd0, 32'd0);
         end
      endcase
      repeat (3) send_request(CMD_EXEC, 12'($urandom), $urandom);
      repeat (10) send_request(($urandom_range(0, 1) == 0) ? CMD_WRITE : CMD_READ,
                               12'($urandom), $urandom);
      drain();
      repeat (20) @(posedge clock);

      $display("Ran %0d requests; the core executed %0d instructions.",
               sent, last_result.executed_count);
      $display("Final stop status %0d after program length and step limit changes.",
               last_result.status);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
